@@ rtl/core/five_stage_load_store_alu_pipeline_macros.svh @@
// assertion macros for the five-stage load/store alu pipeline
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef FIVE_STAGE_LOAD_STORE_ALU_PIPELINE_MACROS_SVH
`define FIVE_STAGE_LOAD_STORE_ALU_PIPELINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define FSLSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FSLSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/fslsa_pkg.sv @@
// shared types and constants for the five-stage load/store alu pipeline
// no dependencies
package fslsa_pkg;

  // data memory and register file geometry
  localparam int MEM_DEPTH = 1024;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int RF_DEPTH  = 32;
  localparam int RF_AW     = $clog2(RF_DEPTH);

  // register file reset value is this base plus the register index
  localparam logic [31:0] RF_RESET_BASE = 32'h0000_0100;

  // instruction encodings
  localparam logic [5:0] OPC_RTYPE = 6'h00;
  localparam logic [5:0] OPC_LB    = 6'h20;
  localparam logic [5:0] OPC_SB    = 6'h28;
  localparam logic [5:0] FUNCT_ADD = 6'h20;
  localparam logic [5:0] FUNCT_SUB = 6'h22;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_LB  = 2'd2,
    OP_SB  = 2'd3
  } op_e;

  // decoded control of one instruction
  typedef struct packed {
    logic        valid;
    op_e         op;
    logic [4:0]  dest;
    logic [31:0] off;
  } dec_t;

endpackage

@@ rtl/core/fslsa_if.sv @@
// request channels of the five-stage load/store alu pipeline
// depends on nothing; one interface for instructions, one for results
interface fslsa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

interface fslsa_out_if;
  logic        valid;
  logic        ready;
  logic        reg_write_valid;
  logic [4:0]  reg_write_index;
  logic [31:0] reg_write_value;
  logic        mem_write_valid;
  logic [9:0]  mem_write_address;
  logic [7:0]  mem_write_byte;

  modport source (output valid, output reg_write_valid, output reg_write_index,
                  output reg_write_value, output mem_write_valid,
                  output mem_write_address, output mem_write_byte, input ready);
  modport sink   (input valid, input reg_write_valid, input reg_write_index,
                  input reg_write_value, input mem_write_valid,
                  input mem_write_address, input mem_write_byte, output ready);
endinterface

@@ rtl/core/fslsa_decode.sv @@
// instruction decoder: opcode/funct to operation, destination and offset
// depends on fslsa_pkg
module fslsa_decode (
  input  logic                word_valid_i,
  input  logic [31:0]         word_i,
  output fslsa_pkg::dec_t     dec_o
);

  logic [5:0]  opc;
  logic [5:0]  funct;
  logic [31:0] imm_sext;

  assign opc      = word_i[31:26];
  assign funct    = word_i[5:0];
  assign imm_sext = {{16{word_i[15]}}, word_i[15:0]};

  // unknown opcode or funct decodes to a bubble
  always_comb begin
    dec_o       = '0;
    dec_o.op    = fslsa_pkg::OP_ADD;
    if (opc == fslsa_pkg::OPC_RTYPE && funct == fslsa_pkg::FUNCT_ADD) begin
      dec_o.valid = word_valid_i;
      dec_o.op    = fslsa_pkg::OP_ADD;
      dec_o.dest  = word_i[15:11];
    end else if (opc == fslsa_pkg::OPC_RTYPE && funct == fslsa_pkg::FUNCT_SUB) begin
      dec_o.valid = word_valid_i;
      dec_o.op    = fslsa_pkg::OP_SUB;
      dec_o.dest  = word_i[15:11];
    end else if (opc == fslsa_pkg::OPC_LB) begin
      dec_o.valid = word_valid_i;
      dec_o.op    = fslsa_pkg::OP_LB;
      dec_o.dest  = word_i[20:16];
      dec_o.off   = imm_sext;
    end else if (opc == fslsa_pkg::OPC_SB) begin
      dec_o.valid = word_valid_i;
      dec_o.op    = fslsa_pkg::OP_SB;
      dec_o.off   = imm_sext;
    end
  end

endmodule

@@ rtl/core/five_stage_load_store_alu_pipeline.sv @@
// five-stage load/store alu pipeline: stages advance only on an accepted request
// an accept shows the result of the instruction leaving memory/writeback
// throughput: one request per cycle unless the output stalls or a clear runs;
// register file and data memory are synchronous rams read one request ahead,
// with write-to-read forwarding; reset: a clearing pass over every ram address
// loads both rams, during which no request is accepted
module five_stage_load_store_alu_pipeline (
  input  logic       clk_i,
  input  logic       rst_ni,
  fslsa_in_if.sink   in_i,
  fslsa_out_if.source out_o
);

  localparam int CLR_LEN = (fslsa_pkg::MEM_DEPTH > fslsa_pkg::RF_DEPTH) ?
                           fslsa_pkg::MEM_DEPTH : fslsa_pkg::RF_DEPTH;
  localparam int CLR_W   = $clog2(CLR_LEN);
  localparam int AW      = fslsa_pkg::MEM_AW;
  localparam int RW      = fslsa_pkg::RF_AW;

  typedef struct packed {
    logic        valid;
    logic [31:0] word;
  } fd_t;

  typedef struct packed {
    logic            valid;
    fslsa_pkg::op_e  op;
    logic [31:0]     a;
    logic [31:0]     b;
    logic [31:0]     off;
    logic [4:0]      dest;
  } de_t;

  typedef struct packed {
    logic            valid;
    fslsa_pkg::op_e  op;
    logic [31:0]     result;
    logic [7:0]      sbyte;
    logic [4:0]      dest;
  } em_t;

  typedef struct packed {
    logic        valid;
    logic [4:0]  dest;
    logic [31:0] value;
  } mw_t;

  // memories
  logic [31:0] rf_mem [fslsa_pkg::RF_DEPTH];
  logic [7:0]  dm_mem [fslsa_pkg::MEM_DEPTH];

  // clearing pass
  logic             clearing_q, clearing_d;
  logic [CLR_W-1:0] clr_q, clr_d;

  // pipeline stages
  fd_t fd_q, fd_d;
  de_t de_q, de_d;
  em_t em_q, em_d;
  mw_t mw_q, mw_d;

  // ram read data and forwarding
  logic [31:0] rda_q, rdb_q, fwd_val_q;
  logic        fwda_q, fwda_d, fwdb_q, fwdb_d;
  logic [7:0]  drd_q, dfwd_byte_q;
  logic        dfwd_q, dfwd_d;

  // output register
  logic        out_valid_q;
  logic        o_rwv_q, o_mwv_q;
  logic [4:0]  o_rwi_q;
  logic [31:0] o_rwval_q;
  logic [9:0]  o_mwa_q;
  logic [7:0]  o_mwb_q;

  logic            acc;
  logic [RW-1:0]   rs_addr, rt_addr;
  logic            rf_we;
  logic [RW-1:0]   rf_wa;
  logic [31:0]     rf_wd;
  logic            dm_we;
  logic [AW-1:0]   dm_wa;
  logic [7:0]      dm_wd;
  logic            wb_we, st_we;
  logic [AW-1:0]   st_addr, ex_addr;
  logic [31:0]     ex_result;
  logic [7:0]      lb_byte;
  logic            clr_rf_en, clr_dm_en;
  fslsa_pkg::dec_t dec;

  // handshake
  assign in_i.ready = !clearing_q && (!out_valid_q || out_o.ready);
  assign acc        = in_i.valid && in_i.ready;

  // clearing pass sequencing
  assign clr_rf_en = {1'b0, clr_q} < (CLR_W + 1)'(fslsa_pkg::RF_DEPTH);
  assign clr_dm_en = {1'b0, clr_q} < (CLR_W + 1)'(fslsa_pkg::MEM_DEPTH);

  always_comb begin
    clearing_d = clearing_q;
    clr_d      = clr_q;
    if (clearing_q) begin
      clr_d = clr_q + 1'b1;
      if (clr_q == CLR_W'(CLR_LEN - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  // decode of the fetch/decode latch
  fslsa_decode u_decode (
    .word_valid_i (fd_q.valid),
    .word_i       (fd_q.word),
    .dec_o        (dec)
  );

  // register read addresses come from the instruction entering fetch/decode
  assign rs_addr = in_i.instruction[25:21];
  assign rt_addr = in_i.instruction[20:16];

  // writeback and store of the current cycle
  assign wb_we   = acc && mw_q.valid;
  assign st_we   = acc && em_q.valid && (em_q.op == fslsa_pkg::OP_SB);
  assign st_addr = em_q.result[AW-1:0];

  // execute
  always_comb begin
    case (de_q.op)
      fslsa_pkg::OP_ADD: ex_result = de_q.a + de_q.b;
      fslsa_pkg::OP_SUB: ex_result = de_q.a - de_q.b;
      default:           ex_result = de_q.a + de_q.off;
    endcase
  end
  assign ex_addr = ex_result[AW-1:0];

  // forwarding of writes that land at the same edge as a read
  assign fwda_d = wb_we && (mw_q.dest == rs_addr);
  assign fwdb_d = wb_we && (mw_q.dest == rt_addr);
  assign dfwd_d = st_we && (st_addr == ex_addr);
  assign lb_byte = dfwd_q ? dfwd_byte_q : drd_q;

  // next stage contents
  always_comb begin
    fd_d.valid = in_i.instruction != 32'd0;
    fd_d.word  = in_i.instruction;

    de_d.valid = dec.valid;
    de_d.op    = dec.op;
    de_d.a     = fwda_q ? fwd_val_q : rda_q;
    de_d.b     = fwdb_q ? fwd_val_q : rdb_q;
    de_d.off   = dec.off;
    de_d.dest  = dec.dest;

    em_d.valid  = de_q.valid;
    em_d.op     = de_q.op;
    em_d.result = ex_result;
    em_d.sbyte  = de_q.b[7:0];
    em_d.dest   = de_q.dest;

    mw_d.valid = em_q.valid && (em_q.op != fslsa_pkg::OP_SB);
    mw_d.dest  = em_q.dest;
    mw_d.value = (em_q.op == fslsa_pkg::OP_LB) ? {24'd0, lb_byte} : em_q.result;
  end

  // ram write port selection: clearing pass or pipeline
  always_comb begin
    if (clearing_q) begin
      rf_we = clr_rf_en;
      rf_wa = clr_q[RW-1:0];
      rf_wd = fslsa_pkg::RF_RESET_BASE + 32'(clr_q[RW-1:0]);
      dm_we = clr_dm_en;
      dm_wa = clr_q[AW-1:0];
      dm_wd = 8'(clr_q);
    end else begin
      rf_we = wb_we;
      rf_wa = mw_q.dest;
      rf_wd = mw_q.value;
      dm_we = st_we;
      dm_wa = st_addr;
      dm_wd = em_q.sbyte;
    end
  end

  // register file ram, two registered read ports
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
    if (acc) begin
      rda_q     <= rf_mem[rs_addr];
      rdb_q     <= rf_mem[rt_addr];
      fwd_val_q <= mw_q.value;
    end
  end

  // data memory ram, one registered read port
  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dm_mem[dm_wa] <= dm_wd;
    end
    if (acc) begin
      drd_q       <= dm_mem[ex_addr];
      dfwd_byte_q <= em_q.sbyte;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
      fd_q       <= '0;
      de_q       <= '0;
      em_q       <= '0;
      mw_q       <= '0;
      fwda_q     <= 1'b0;
      fwdb_q     <= 1'b0;
      dfwd_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_q      <= clr_d;
      if (acc) begin
        fd_q   <= fd_d;
        de_q   <= de_d;
        em_q   <= em_d;
        mw_q   <= mw_d;
        fwda_q <= fwda_d;
        fwdb_q <= fwdb_d;
        dfwd_q <= dfwd_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, idle fields read zero
  always_ff @(posedge clk_i) begin
    if (acc) begin
      o_rwv_q   <= mw_q.valid;
      o_rwi_q   <= mw_q.valid ? mw_q.dest : 5'd0;
      o_rwval_q <= mw_q.valid ? mw_q.value : 32'd0;
      o_mwv_q   <= st_we;
      o_mwa_q   <= st_we ? 10'(st_addr) : 10'd0;
      o_mwb_q   <= st_we ? em_q.sbyte : 8'd0;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.reg_write_valid   = o_rwv_q;
  assign out_o.reg_write_index   = o_rwi_q;
  assign out_o.reg_write_value   = o_rwval_q;
  assign out_o.mem_write_valid   = o_mwv_q;
  assign out_o.mem_write_address = o_mwa_q;
  assign out_o.mem_write_byte    = o_mwb_q;

  // checks
`include "five_stage_load_store_alu_pipeline_macros.svh"

  `FSLSA_ASSERT_NOW(a_no_req_while_clearing, clearing_q, !in_i.ready, "request taken during clear")
  `FSLSA_ASSERT_NEXT(a_req_gives_result, acc, out_o.valid, "accepted request gave no result")
  `FSLSA_ASSERT_NEXT(a_store_reported, st_we, out_o.mem_write_valid, "store not reported")
  `FSLSA_ASSERT_NEXT(a_bubble_stays, acc && !fd_q.valid, !de_q.valid, "bubble became valid in decode")

endmodule
